// ===== src/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg: shared definitions for the LED pattern player
// Field widths, input kind and register codes, reset values, frame tables,
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package lpp_pkg;

    // Number of built-in patterns.
    localparam int NUM_PATTERNS_C = 5;

    // Field widths.
    localparam int KIND_W    = 3;
    localparam int PAT_W     = 3;
    localparam int LED_W     = 8;
    localparam int PERIOD_W  = 16;
    localparam int FRAME_W   = 6;
    localparam int ROM_AW    = 7;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;
    localparam int CFG_IDX_W = 2;

    // Divider geometry: product of two periods over one period.
    localparam int DIVIDEND_W = 2 * PERIOD_W;
    localparam int DIVISOR_W  = PERIOD_W;
    localparam int DIV_BITS   = 2;

    // Input kinds.
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FASTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLOWER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUIT   = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_INITIAL = 2'd3;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MIN     = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MAX     = 16'd1600;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_STEP    = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_INITIAL = 16'd900;

    // All frames of all patterns, back to back.
    localparam logic [LED_W-1:0] FRAME_ROM [0:111] = '{
        // bounce
        8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
        // crash
        8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42,
        // police
        8'hF0, 8'h00, 8'hF0, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00,
        8'h0F, 8'h00, 8'h0F, 8'h00, 8'h0F, 8'h00, 8'h00, 8'h00,
        8'hF0, 8'hF0, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h0F, 8'h0F, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        // stone in pond
        8'h80, 8'h40, 8'h20, 8'h10, 8'h18, 8'h24, 8'h42, 8'h81,
        8'h81, 8'h42, 8'h42, 8'h42, 8'h24, 8'h24, 8'h24, 8'h18,
        8'h18, 8'h18, 8'h00, 8'h00,
        // traffic jam
        8'h80, 8'h40, 8'hA0, 8'h50, 8'hA8, 8'h54, 8'hAA, 8'h55,
        8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
        8'h55, 8'h55, 8'h55, 8'h55, 8'h55,
        8'h54, 8'h52, 8'h51, 8'h50,
        8'h48, 8'h44, 8'h42, 8'h41, 8'h40,
        8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Number of frames in a pattern.
    function automatic logic [FRAME_W-1:0] frame_len(input logic [PAT_W-1:0] pat);
        logic [FRAME_W-1:0] len;
        case (pat)
            3'd0:    len = 6'd14;
            3'd1:    len = 6'd7;
            3'd2:    len = 6'd32;
            3'd3:    len = 6'd20;
            3'd4:    len = 6'd39;
            default: len = 6'd14;
        endcase
        return len;
    endfunction

    // First frame of a pattern in the frame table.
    function automatic logic [ROM_AW-1:0] frame_base(input logic [PAT_W-1:0] pat);
        logic [ROM_AW-1:0] base;
        case (pat)
            3'd0:    base = 7'd0;
            3'd1:    base = 7'd14;
            3'd2:    base = 7'd21;
            3'd3:    base = 7'd53;
            3'd4:    base = 7'd73;
            default: base = 7'd0;
        endcase
        return base;
    endfunction

    // LED word of one frame; an index past the end shows the first frame.
    function automatic logic [LED_W-1:0] frame_leds(input logic [PAT_W-1:0]   pat,
                                                    input logic [FRAME_W-1:0] fi);
        logic [FRAME_W-1:0] f;
        logic [ROM_AW-1:0]  idx;
        f   = (fi < frame_len(pat)) ? fi : '0;
        idx = frame_base(pat) + {1'b0, f};
        return FRAME_ROM[idx];
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic div_start;
        logic wb;
        logic load_out;
    } lpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rescale_req;
        logic div_done;
    } lpp_sts_t;

endpackage

// ===== src/lpp_div.sv =====
// ----------------------------------------------------------------------------
// lpp_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle, 32-bit dividend over a
// 16-bit divisor.
// ----------------------------------------------------------------------------
module lpp_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lpp_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [lpp_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [lpp_pkg::DIVIDEND_W-1:0]   quotient
);
    import lpp_pkg::*;

    localparam int STEPS = DIVIDEND_W / DIV_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  step_rem;
    logic [DIVIDEND_W-1:0] step_quo;
    logic [DIVISOR_W:0]    shifted;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        shifted  = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            shifted  = {step_rem, step_quo[DIVIDEND_W-1]};
            step_quo = {step_quo[DIVIDEND_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
            begin
                shifted     = shifted - {1'b0, dvs_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = shifted[DIVISOR_W-1:0];
        end
    end

    // Iteration control.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

// ===== src/lpp_dp.sv =====
// ----------------------------------------------------------------------------
// lpp_dp: datapath of the LED pattern player
// Holds the play state, the per-pattern periods, the setting registers and
// the output word, and rescales the frame countdown through the divider.
// ----------------------------------------------------------------------------
module lpp_dp #(
    parameter int NUM_PATTERNS = lpp_pkg::NUM_PATTERNS_C
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpp_pkg::lpp_cmd_t               cmd,
    output lpp_pkg::lpp_sts_t               sts,
    input  logic [lpp_pkg::KIND_W-1:0]      kind,
    input  logic [lpp_pkg::PAT_W-1:0]       pattern,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpp_pkg::CFG_AW-1:0]      paddr,
    input  logic [lpp_pkg::CFG_DW-1:0]      pwdata,
    output logic [lpp_pkg::CFG_DW-1:0]      prdata,
    output logic [lpp_pkg::LED_W-1:0]       leds,
    output logic [lpp_pkg::PERIOD_W-1:0]    period_now,
    output logic                            running
);
    import lpp_pkg::*;

    localparam int IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam logic [PAT_W:0] NUM_PAT_L = (PAT_W + 1)'(NUM_PATTERNS);

    // Item and play state.
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [PAT_W-1:0]    pat_reg, pat_next;
    logic                active_reg, active_next;
    logic [PAT_W-1:0]    cur_pat_reg, cur_pat_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [PERIOD_W-1:0] ticks_reg, ticks_next;
    logic [PERIOD_W-1:0] np_reg, np_next;
    logic [PERIOD_W-1:0] period_reg [NUM_PATTERNS];
    logic [PERIOD_W-1:0] period_next [NUM_PATTERNS];

    // Setting registers.
    logic [PERIOD_W-1:0] pmin_reg, pmin_next;
    logic [PERIOD_W-1:0] pmax_reg, pmax_next;
    logic [PERIOD_W-1:0] pstep_reg, pstep_next;
    logic [PERIOD_W-1:0] pinit_reg, pinit_next;

    // Output word.
    logic [LED_W-1:0]    leds_reg, leds_next;
    logic [PERIOD_W-1:0] period_now_reg, period_now_next;
    logic                running_reg, running_next;

    logic                  start_ok;
    logic [PAT_W-1:0]      rd_sel;
    logic [IDX_W-1:0]      rd_idx;
    logic [PERIOD_W-1:0]   per;
    logic [PERIOD_W-1:0]   ticks_dec;
    logic [FRAME_W:0]      frame_inc;
    logic [FRAME_W-1:0]    frame_wrap;
    logic [PERIOD_W-1:0]   np_fast;
    logic [PERIOD_W:0]     np_sum;
    logic [PERIOD_W-1:0]   np_slow;
    logic [PERIOD_W-1:0]   np_raw;
    logic [PERIOD_W-1:0]   np_z;
    logic                  speed_ok;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [PERIOD_W-1:0]   cfg_val;
    logic [PERIOD_W-1:0]   cfg_val_nz;
    logic [DIVIDEND_W-1:0] product;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;

    // One period read port: the new pattern on a start, else the running one.
    assign start_ok = (kind_reg == KIND_START) && ({1'b0, pat_reg} < NUM_PAT_L);
    assign rd_sel   = start_ok ? pat_reg : cur_pat_reg;
    assign rd_idx   = rd_sel[IDX_W-1:0];
    assign per      = period_reg[rd_idx];

    // Tick: count down, advance and wrap the frame when the count runs out.
    assign ticks_dec  = (ticks_reg != '0) ? ticks_reg - 1'b1 : '0;
    assign frame_inc  = {1'b0, frame_reg} + 1'b1;
    assign frame_wrap = (frame_inc >= {1'b0, frame_len(cur_pat_reg)}) ?
                        '0 : frame_inc[FRAME_W-1:0];

    // Speed keys: step the period and clamp it to the limits.
    assign np_fast  = (per > pstep_reg) ? per - pstep_reg : '0;
    assign np_sum   = {1'b0, per} + {1'b0, pstep_reg};
    assign np_slow  = (np_sum > {1'b0, pmax_reg}) ? pmax_reg : np_sum[PERIOD_W-1:0];
    assign np_raw   = (kind_reg == KIND_FASTER) ?
                      ((np_fast < pmin_reg) ? pmin_reg : np_fast) : np_slow;
    assign np_z     = (np_raw == '0) ? PERIOD_W'(1) : np_raw;
    assign speed_ok = active_reg &&
                      (((kind_reg == KIND_FASTER) && (per > pmin_reg)) ||
                       ((kind_reg == KIND_SLOWER) && (per < pmax_reg)));

    assign sts.rescale_req = cmd.exec && speed_ok && (np_z != per);
    assign sts.div_done    = div_done;

    // Rescale of the remaining ticks: left * new / old.
    assign product = DIVIDEND_W'(ticks_reg) * DIVIDEND_W'(np_reg);

    lpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (per),
        .done     (div_done),
        .quotient (quotient)
    );

    // Setting port decode.
    assign cfg_we     = psel && penable && pwrite;
    assign cfg_idx    = paddr[CFG_AW-1:2];
    assign cfg_val    = pwdata[PERIOD_W-1:0];
    assign cfg_val_nz = (cfg_val == '0) ? PERIOD_W'(1) : cfg_val;

    always_comb
    begin
        case (cfg_idx)
            REG_PERIOD_MIN:     prdata = CFG_DW'(pmin_reg);
            REG_PERIOD_MAX:     prdata = CFG_DW'(pmax_reg);
            REG_PERIOD_STEP:    prdata = CFG_DW'(pstep_reg);
            REG_PERIOD_INITIAL: prdata = CFG_DW'(pinit_reg);
            default:            prdata = '0;
        endcase
    end

    // Next-state logic for every register of the datapath.
    always_comb
    begin
        kind_next       = kind_reg;
        pat_next        = pat_reg;
        active_next     = active_reg;
        cur_pat_next    = cur_pat_reg;
        frame_next      = frame_reg;
        ticks_next      = ticks_reg;
        np_next         = np_reg;
        period_next     = period_reg;
        pmin_next       = pmin_reg;
        pmax_next       = pmax_reg;
        pstep_next      = pstep_reg;
        pinit_next      = pinit_reg;
        leds_next       = leds_reg;
        period_now_next = period_now_reg;
        running_next    = running_reg;

        if (cmd.latch)
        begin
            kind_next = kind;
            pat_next  = pattern;
        end

        if (cmd.exec)
        begin
            np_next = np_z;
            case (kind_reg)
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        if (ticks_dec == '0)
                        begin
                            frame_next = frame_wrap;
                            ticks_next = per;
                        end
                        else
                        begin
                            ticks_next = ticks_dec;
                        end
                    end
                end
                KIND_START:
                begin
                    if (start_ok)
                    begin
                        cur_pat_next = pat_reg;
                        active_next  = 1'b1;
                        frame_next   = '0;
                        ticks_next   = per;
                    end
                end
                KIND_QUIT:
                begin
                    active_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // A quotient of zero still leaves one tick in the frame.
        if (cmd.wb)
        begin
            ticks_next          = (quotient == '0) ? PERIOD_W'(1) : quotient[PERIOD_W-1:0];
            period_next[rd_idx] = np_reg;
        end

        if (cfg_we)
        begin
            case (cfg_idx)
                REG_PERIOD_MIN:  pmin_next  = cfg_val;
                REG_PERIOD_MAX:  pmax_next  = cfg_val;
                REG_PERIOD_STEP: pstep_next = cfg_val;
                REG_PERIOD_INITIAL:
                begin
                    pinit_next = cfg_val;
                    for (int i = 0; i < NUM_PATTERNS; i++)
                    begin
                        period_next[i] = cfg_val_nz;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.load_out)
        begin
            leds_next       = active_reg ? frame_leds(cur_pat_reg, frame_reg) : '0;
            period_now_next = per;
            running_next    = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= '0;
            pat_reg     <= '0;
            active_reg  <= 1'b0;
            cur_pat_reg <= '0;
            frame_reg   <= '0;
            ticks_reg   <= '0;
            pmin_reg    <= RST_PERIOD_MIN;
            pmax_reg    <= RST_PERIOD_MAX;
            pstep_reg   <= RST_PERIOD_STEP;
            pinit_reg   <= RST_PERIOD_INITIAL;
            for (int i = 0; i < NUM_PATTERNS; i++)
            begin
                period_reg[i] <= RST_PERIOD_INITIAL;
            end
        end
        else
        begin
            kind_reg    <= kind_next;
            pat_reg     <= pat_next;
            active_reg  <= active_next;
            cur_pat_reg <= cur_pat_next;
            frame_reg   <= frame_next;
            ticks_reg   <= ticks_next;
            pmin_reg    <= pmin_next;
            pmax_reg    <= pmax_next;
            pstep_reg   <= pstep_next;
            pinit_reg   <= pinit_next;
            period_reg  <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        np_reg         <= np_next;
        leds_reg       <= leds_next;
        period_now_reg <= period_now_next;
        running_reg    <= running_next;
    end

    assign leds       = leds_reg;
    assign period_now = period_now_reg;
    assign running    = running_reg;

    // The frame index always lies inside the running pattern.
    a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg < frame_len(cur_pat_reg))
        else $error("frame index beyond the end of the pattern");

    // No period of the selected pattern ever reads as zero.
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        per != '0)
        else $error("pattern period is zero");

endmodule

// ===== src/lpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpp_ctrl: controller of the LED pattern player
// Sequences one word through execute, optional rescale and output load, and
// owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module lpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lpp_pkg::lpp_cmd_t cmd,
    input  lpp_pkg::lpp_sts_t sts
);
    import lpp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.rescale_req ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // An accepted word always goes to execute next.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    // A finished word lands in a free output register and frees the input.
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished word not delivered");

    // The end of a division is followed by the write-back.
    a_div_wb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && sts.div_done |=> state_reg == S_WB)
        else $error("division result not written back");

endmodule

// ===== src/led_pattern_player_speed_ctrl.sv =====
// ----------------------------------------------------------------------------
// led_pattern_player_speed_ctrl: LED chaser with per-pattern speed control
// Plays one of five fixed 8-LED frame sequences, stepping each pattern's
// frame period with faster and slower keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: kind and pattern.
//   Kind 0 is a tick, 1 faster, 2 slower, 3 start pattern, 4 quit.
//   Each input word produces exactly one output word (out_valid/out_ready)
//   with the LED frame, the period of the selected pattern and a run flag.
//   A tick, start, quit or a key that leaves the period unchanged goes
//   through execute and output load; a new word is taken only when idle.
//   A key that changes the period rescales the remaining ticks with one
//   16x16 multiply and an iterative divider that retires two quotient bits
//   a cycle, then writes the new period and the remaining ticks back.
//   The output register holds one finished word: while it waits for the
//   receiver, one more input word is taken and worked on; that word then
//   waits until the output register is free.
//   Reset clears the play state and loads every period with 900 ticks and
//   the limits with 100, 1600 and step 100. Settings are written by the user
//   at APB byte offsets 0, 4, 8 and 12, only while idle; this is not checked.
// ----------------------------------------------------------------------------
module led_pattern_player_speed_ctrl #(
    parameter int NUM_PATTERNS = lpp_pkg::NUM_PATTERNS_C
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lpp_pkg::KIND_W-1:0]   kind,
    input  logic [lpp_pkg::PAT_W-1:0]    pattern,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lpp_pkg::LED_W-1:0]    leds,
    output logic [lpp_pkg::PERIOD_W-1:0] period_now,
    output logic                         running,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpp_pkg::CFG_AW-1:0]   paddr,
    input  logic [lpp_pkg::CFG_DW-1:0]   pwdata,
    output logic [lpp_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);
    import lpp_pkg::*;

    lpp_cmd_t cmd;
    lpp_sts_t sts;

    // Register access never stalls.
    assign pready = 1'b1;

    // Sequencing of each word.
    lpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Play state, periods, settings and output word.
    lpp_dp #(
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .pattern    (pattern),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .leds       (leds),
        .period_now (period_now),
        .running    (running)
    );

endmodule
